>>> hdl/u8u16_pkg.sv
// Shared types, constants and byte classification for the UTF-8 to UTF-16 decoder.
package u8u16_pkg;

  localparam int unsigned QUEUE_DEPTH = 4;

  localparam logic [15:0] REPLACEMENT_UNIT = 16'hFFFD;
  localparam logic [15:0] HIGH_SURR_BASE   = 16'hD800;
  localparam logic [15:0] LOW_SURR_BASE    = 16'hDC00;
  localparam logic [20:0] SUPP_OFFSET      = 21'h10000;

  localparam logic [7:0] CONT_MASK  = 8'hC0;
  localparam logic [7:0] CONT_MARK  = 8'h80;
  localparam logic [7:0] LEAD2_MASK = 8'hE0;
  localparam logic [7:0] LEAD2_MARK = 8'hC0;
  localparam logic [7:0] LEAD3_MASK = 8'hF0;
  localparam logic [7:0] LEAD3_MARK = 8'hE0;
  localparam logic [7:0] LEAD4_MASK = 8'hF8;
  localparam logic [7:0] LEAD4_MARK = 8'hF0;

  typedef struct packed {
    logic [7:0] data;
    logic       eot;
    logic [2:0] lead_len;
    logic       is_cont;
  } byte_item_t;

  function automatic logic [2:0] lead_length(input logic [7:0] b);
    logic [2:0] len;
    if (b[7] == 1'b0) begin
      len = 3'd1;
    end else if ((b & LEAD2_MASK) == LEAD2_MARK) begin
      len = 3'd2;
    end else if ((b & LEAD3_MASK) == LEAD3_MARK) begin
      len = 3'd3;
    end else if ((b & LEAD4_MASK) == LEAD4_MARK) begin
      len = 3'd4;
    end else begin
      len = 3'd0;
    end
    return len;
  endfunction

  function automatic byte_item_t classify(input logic [7:0] b, input logic eot);
    byte_item_t it;
    it.data     = b;
    it.eot      = eot;
    it.lead_len = lead_length(b);
    it.is_cont  = ((b & CONT_MASK) == CONT_MARK);
    return it;
  endfunction

endpackage

>>> hdl/utf8_to_utf16_decoder.sv
// UTF-8 to UTF-16 decoder top level: byte queue front end and decode back end.
// Throughput: one byte per cycle while the output is not stalled; the low half of a surrogate
// pair and each byte decoded again after a bad continuation hold off new bytes in the back end.
// The back end emits at most one code unit per cycle through its output register, and holds it while out_ready is low.
// Reset: synchronous; empties the byte queue, the pending window and the output register.
module utf8_to_utf16_decoder #(
  parameter int unsigned QUEUE_DEPTH = u8u16_pkg::QUEUE_DEPTH
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_byte,
  input  logic        end_of_text,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [15:0] code_unit,
  output logic        last_unit
);

  logic                  q_valid;
  logic                  q_ready;
  u8u16_pkg::byte_item_t q_item;

  u8u16_front #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_front (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_byte     (in_byte),
    .end_of_text (end_of_text),
    .q_valid     (q_valid),
    .q_item      (q_item),
    .q_ready     (q_ready)
  );

  u8u16_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (q_valid),
    .q_item    (q_item),
    .q_ready   (q_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .code_unit (code_unit),
    .last_unit (last_unit)
  );

endmodule

>>> hdl/u8u16_front.sv
// Front end: accept input bytes, classify them and queue them for the decoder.
module u8u16_front #(
  parameter int unsigned QUEUE_DEPTH = u8u16_pkg::QUEUE_DEPTH
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [7:0]            in_byte,
  input  logic                  end_of_text,
  output logic                  q_valid,
  output u8u16_pkg::byte_item_t q_item,
  input  logic                  q_ready
);

  localparam int unsigned PW = $clog2(QUEUE_DEPTH);
  localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);
  localparam logic [CW-1:0] FULL = CW'(QUEUE_DEPTH);
  localparam logic [PW-1:0] LAST_SLOT = PW'(QUEUE_DEPTH - 1);

  u8u16_pkg::byte_item_t slots [QUEUE_DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [CW-1:0] count;
  logic          push;
  logic          pop;

  assign in_ready = (count != FULL);
  assign q_valid  = (count != '0);
  assign q_item   = slots[rd_ptr];
  assign push     = in_valid && in_ready;
  assign pop      = q_valid && q_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= u8u16_pkg::classify(in_byte, end_of_text);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == LAST_SLOT) ? '0 : wr_ptr + PW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == LAST_SLOT) ? '0 : rd_ptr + PW'(1);
      end
      if (push && !pop) begin
        count <= count + CW'(1);
      end else if (pop && !push) begin
        count <= count - CW'(1);
      end
    end
  end

endmodule

>>> hdl/u8u16_back.sv
// Back end: byte window, sequence decode, surrogate split and output register.
module u8u16_back (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  q_valid,
  input  u8u16_pkg::byte_item_t q_item,
  output logic                  q_ready,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [15:0]           code_unit,
  output logic                  last_unit
);

  u8u16_pkg::byte_item_t win [3];
  logic [1:0]  cnt;
  logic        eot_w;
  logic        pair;
  logic [15:0] pair_unit;
  logic        pair_last;

  u8u16_pkg::byte_item_t ext [4];
  u8u16_pkg::byte_item_t win_next [3];
  logic        can_emit;
  logic        take;
  logic [2:0]  en;
  logic        eot_e;
  logic [2:0]  lead;
  logic        bad;
  logic [20:0] cp;
  logic [20:0] sup;
  logic        emit;
  logic [15:0] unit;
  logic [2:0]  consume;
  logic [2:0]  rem;
  logic        pair_set;
  logic [15:0] pair_lo;
  logic        last;

  assign can_emit = !out_valid || out_ready;
  assign q_ready  = take && can_emit;

  always_comb begin
    take = q_valid && !pair && !eot_w &&
           ((cnt == 2'd0) || ((win[0].lead_len != 3'd0) && ({1'b0, cnt} < win[0].lead_len)));
    for (int i = 0; i < 3; i++) begin
      ext[i] = (2'(i) < cnt) ? win[i] : q_item;
    end
    ext[3] = q_item;
    en    = {1'b0, cnt} + {2'b00, take};
    eot_e = eot_w || (take && q_item.eot);
    lead  = ext[0].lead_len;
    bad   = ((lead >= 3'd2) && !ext[1].is_cont) ||
            ((lead >= 3'd3) && !ext[2].is_cont) ||
            ((lead == 3'd4) && !ext[3].is_cont);

    case (lead)
      3'd2:    cp = {10'd0, ext[0].data[4:0], ext[1].data[5:0]};
      3'd3:    cp = {5'd0, ext[0].data[3:0], ext[1].data[5:0], ext[2].data[5:0]};
      3'd4:    cp = {ext[0].data[2:0], ext[1].data[5:0], ext[2].data[5:0],
                     ext[3].data[5:0]};
      default: cp = {13'd0, ext[0].data};
    endcase
    sup     = cp - u8u16_pkg::SUPP_OFFSET;
    pair_lo = u8u16_pkg::LOW_SURR_BASE | {6'd0, sup[9:0]};

    emit     = 1'b0;
    unit     = u8u16_pkg::REPLACEMENT_UNIT;
    consume  = 3'd0;
    pair_set = 1'b0;
    if (pair) begin
      emit = 1'b1;
      unit = pair_unit;
    end else if (en != 3'd0) begin
      if (lead == 3'd0) begin
        emit    = 1'b1;
        consume = 3'd1;
      end else if (en < lead) begin
        if (eot_e) begin
          emit    = 1'b1;
          consume = en;
        end
      end else if (bad) begin
        emit    = 1'b1;
        consume = 3'd1;
      end else begin
        emit    = 1'b1;
        consume = lead;
        if (cp[20:16] != 5'd0) begin
          pair_set = 1'b1;
          unit     = u8u16_pkg::HIGH_SURR_BASE + {5'd0, sup[20:10]};
        end else begin
          unit = cp[15:0];
        end
      end
    end
    rem  = en - consume;
    last = pair ? pair_last : (eot_e && (rem == 3'd0) && !pair_set);

    for (int i = 0; i < 3; i++) begin
      case (consume)
        3'd1:    win_next[i] = ext[(i + 1) % 4];
        3'd2:    win_next[i] = ext[(i + 2) % 4];
        3'd3:    win_next[i] = ext[(i + 3) % 4];
        default: win_next[i] = ext[i];
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (can_emit) begin
      for (int i = 0; i < 3; i++) begin
        win[i] <= win_next[i];
      end
      code_unit <= unit;
      last_unit <= last;
      if (pair_set) begin
        pair_unit <= pair_lo;
        pair_last <= eot_e && (rem == 3'd0);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt       <= 2'd0;
      eot_w     <= 1'b0;
      pair      <= 1'b0;
      out_valid <= 1'b0;
    end else if (can_emit) begin
      cnt       <= rem[1:0];
      eot_w     <= eot_e && (rem != 3'd0);
      pair      <= pair_set;
      out_valid <= emit;
    end
  end

endmodule
